/* hw/rtl/gwh_pkg.sv */
// ----------------------------------------------------------------------------
// gwh_pkg
// Shared widths, register indexes and the job record that travels from the
// front end to the arithmetic back end of the groundwater head update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwh_pkg;

  // Default grid width in columns
  localparam int GRID_COLS_DEF = 128;

  // Field widths
  localparam int CNT_W    = 12;
  localparam int HEAD_W   = 32;
  localparam int COND_W   = 32;
  localparam int YIELD_W  = 16;
  localparam int SRC_W    = 32;
  localparam int TS_W     = 16;
  localparam int AREA_W   = 16;
  localparam int THICK_W  = 10;
  localparam int ROWS_W   = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_AREA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd3;

  // Register reset values
  localparam logic [TS_W-1:0]    TIME_STEP_RST = 16'd4000;
  localparam logic [AREA_W-1:0]  CELL_AREA_RST = 16'd100;
  localparam logic [THICK_W-1:0] THICKNESS_RST = 10'd50;
  localparam logic [ROWS_W-1:0]  GRID_ROWS_RST = 13'd128;

  // Legal row count range
  localparam logic [ROWS_W-1:0] ROWS_MIN = 13'd3;
  localparam logic [ROWS_W-1:0] ROWS_MAX = 13'd4096;

  // One unit of work for the back end: either a plain pass of a head value
  // or a full stencil update of one cell.
  typedef struct packed {
    logic                        calc;
    logic [CNT_W-1:0]            row;
    logic [CNT_W-1:0]            col;
    logic                        last;
    logic [HEAD_W-1:0]           hc;
    logic [3:0][HEAD_W-1:0]      nh;
    logic [3:0][COND_W-1:0]      nk;
    logic [3:0]                  nv;
    logic [YIELD_W-1:0]          sy;
    logic [SRC_W-1:0]            src;
  } job_t;

endpackage

`default_nettype wire

/* hw/rtl/gwh_if.sv */
// ----------------------------------------------------------------------------
// gwh_if
// Channel interfaces: cell input stream, result stream, register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gwh_cell_if import gwh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [HEAD_W-1:0]  cell_head;
  logic [COND_W-1:0]         conductivity;
  logic [YIELD_W-1:0]        specific_yield;
  logic signed [SRC_W-1:0]   source_rate;

  modport source(output valid, cell_head, conductivity, specific_yield, source_rate,
                 input ready);
  modport sink(input valid, cell_head, conductivity, specific_yield, source_rate,
               output ready);
endinterface

interface gwh_result_if import gwh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CNT_W-1:0]          row_index;
  logic [CNT_W-1:0]          column_index;
  logic signed [HEAD_W-1:0]  new_head;
  logic                      last_of_run;

  modport source(output valid, row_index, column_index, new_head, last_of_run,
                 input ready);
  modport sink(input valid, row_index, column_index, new_head, last_of_run,
               output ready);
endinterface

interface gwh_cfg_if import gwh_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gwh_ram.sv */
// ----------------------------------------------------------------------------
// gwh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/gwh_job_fifo.sv */
// ----------------------------------------------------------------------------
// gwh_job_fifo
// Two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwh_job_fifo import gwh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slots[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gwh_front.sv */
// ----------------------------------------------------------------------------
// gwh_front
// Accepts cells, tracks row and column, reads the neighbor values from the
// line stores, writes the new cell back and queues the jobs it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwh_front import gwh_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  gwh_cell_if.sink          cells,
  input  logic [ROWS_W-1:0] grid_rows,
  output logic              push,
  output job_t              push_job,
  input  logic              full
);

  localparam int CW = $clog2(GRID_COLS);
  localparam int HD = 2 ** (CW + 1);
  localparam int LD = 2 ** CW;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_READ  = 3'd1;
  localparam logic [2:0] F_LAST  = 3'd2;
  localparam logic [2:0] F_PUSH1 = 3'd3;
  localparam logic [2:0] F_PUSH2 = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  row_cnt;
  logic [CNT_W-1:0]  col_cnt;
  logic [1:0]        rcnt;

  logic [CNT_W-1:0]  lat_r;
  logic [CNT_W-1:0]  lat_c;
  logic              lat_emit;
  logic              lat_edge;
  logic              lat_last;
  logic [HEAD_W-1:0] lat_head;
  logic [COND_W-1:0] lat_cond;
  logic [YIELD_W-1:0] lat_sy;
  logic [SRC_W-1:0]  lat_src;

  logic [3:0][HEAD_W-1:0] rd_head;
  logic [3:0][COND_W-1:0] rd_cond;
  logic [YIELD_W-1:0]     rd_sy;
  logic [SRC_W-1:0]       rd_src;

  logic [HEAD_W-1:0]  h_q;
  logic [COND_W-1:0]  k_q;
  logic [YIELD_W-1:0] y_q;
  logic [SRC_W-1:0]   s_q;

  logic              accept;
  logic [ROWS_W-1:0] rows_c;
  logic [CNT_W-1:0]  c_eff;
  logic              is_last;
  logic [CNT_W:0]    c_inc;
  logic              col_wrap;
  logic [CW-1:0]     col_ix;
  logic              cur;
  logic [CW:0]       raddr_h;
  logic [CW-1:0]     raddr_l;
  logic              cap;
  logic [1:0]        cap_idx;
  logic              we;
  logic              nv2;
  logic              nv3;

  assign accept      = cells.valid && cells.ready;
  assign cells.ready = (state == F_IDLE) && !rst;

  // Row count clamp, position of this cell and end-of-row test
  always_comb begin
    if (grid_rows < ROWS_MIN) begin
      rows_c = ROWS_MIN;
    end else if (grid_rows > ROWS_MAX) begin
      rows_c = ROWS_MAX;
    end else begin
      rows_c = grid_rows;
    end
    c_eff    = ({1'b0, col_cnt} >= (CNT_W + 1)'(GRID_COLS)) ? '0 : col_cnt;
    is_last  = {1'b0, row_cnt} >= (rows_c - ROWS_W'(1));
    c_inc    = {1'b0, c_eff} + (CNT_W + 1)'(1);
    col_wrap = c_inc >= (CNT_W + 1)'(GRID_COLS);
  end

  assign col_ix = lat_c[CW-1:0];
  assign cur    = lat_r[0];
  assign nv2    = (lat_c != '0);
  assign nv3    = (({1'b0, lat_c} + (CNT_W + 1)'(1)) < (CNT_W + 1)'(GRID_COLS));

  // Read addresses: upper row at c, then previous row at c-1, c, c+1
  always_comb begin
    case (rcnt)
      2'd0:    raddr_h = {cur, col_ix};
      2'd1:    raddr_h = {~cur, col_ix - CW'(1)};
      2'd2:    raddr_h = {~cur, col_ix};
      2'd3:    raddr_h = {~cur, col_ix + CW'(1)};
      default: raddr_h = {cur, col_ix};
    endcase
    raddr_l = col_ix;
  end

  assign cap     = ((state == F_READ) && (rcnt != 2'd0)) || (state == F_LAST);
  assign cap_idx = (state == F_LAST) ? 2'd3 : (rcnt - 2'd1);
  assign we      = (state == F_LAST);

  // Line stores
  gwh_ram #(.WIDTH(HEAD_W), .DEPTH(HD)) u_head_ram (
    .clk(clk), .we(we), .waddr({cur, col_ix}), .wdata(lat_head),
    .raddr(raddr_h), .rdata(h_q)
  );

  gwh_ram #(.WIDTH(COND_W), .DEPTH(HD)) u_cond_ram (
    .clk(clk), .we(we), .waddr({cur, col_ix}), .wdata(lat_cond),
    .raddr(raddr_h), .rdata(k_q)
  );

  gwh_ram #(.WIDTH(YIELD_W), .DEPTH(LD)) u_yield_ram (
    .clk(clk), .we(we), .waddr(col_ix), .wdata(lat_sy),
    .raddr(raddr_l), .rdata(y_q)
  );

  gwh_ram #(.WIDTH(SRC_W), .DEPTH(LD)) u_src_ram (
    .clk(clk), .we(we), .waddr(col_ix), .wdata(lat_src),
    .raddr(raddr_l), .rdata(s_q)
  );

  // Sequencer and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
      rcnt    <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            rcnt  <= 2'd0;
            state <= F_READ;
            if (col_wrap) begin
              col_cnt <= '0;
              row_cnt <= is_last ? '0 : row_cnt + CNT_W'(1);
            end else begin
              col_cnt <= c_inc[CNT_W-1:0];
            end
          end
        end
        F_READ: begin
          rcnt <= rcnt + 2'd1;
          if (rcnt == 2'd3) begin
            state <= F_LAST;
          end
        end
        F_LAST: begin
          state <= F_PUSH1;
        end
        F_PUSH1: begin
          if (!lat_emit || !full) begin
            state <= F_PUSH2;
          end
        end
        F_PUSH2: begin
          if (!lat_last || !full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Hold the accepted cell and its classification
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_r    <= row_cnt;
      lat_c    <= c_eff;
      lat_emit <= (row_cnt != '0);
      lat_edge <= (row_cnt == CNT_W'(1));
      lat_last <= is_last;
      lat_head <= cells.cell_head;
      lat_cond <= cells.conductivity;
      lat_sy   <= cells.specific_yield;
      lat_src  <= cells.source_rate;
    end
    if (cap) begin
      rd_head[cap_idx] <= h_q;
      rd_cond[cap_idx] <= k_q;
      if (cap_idx == 2'd0) begin
        rd_sy  <= y_q;
        rd_src <= s_q;
      end
    end
  end

  // Job for the cell one row up, then the pass of a last-row cell
  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (state == F_PUSH1) begin
      push          = lat_emit && !full;
      push_job.calc = !lat_edge;
      push_job.row  = lat_r - CNT_W'(1);
      push_job.col  = lat_c;
      push_job.last = !lat_last;
      push_job.hc   = rd_head[2];
      push_job.nh   = {rd_head[3], rd_head[1], lat_head, rd_head[0]};
      push_job.nk   = {rd_cond[3], rd_cond[1], lat_cond, rd_cond[0]};
      push_job.nv   = {nv3, nv2, 2'b11};
      push_job.sy   = rd_sy;
      push_job.src  = rd_src;
    end else if (state == F_PUSH2) begin
      push          = lat_last && !full;
      push_job.calc = 1'b0;
      push_job.row  = lat_r;
      push_job.col  = lat_c;
      push_job.last = 1'b1;
      push_job.hc   = lat_head;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gwh_back.sv */
// ----------------------------------------------------------------------------
// gwh_back
// Carries out one job at a time: flux sum by partial products, scaling by
// the time step, restoring division, saturation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwh_back import gwh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  output logic               pop,
  input  job_t               job_in,
  input  logic [TS_W-1:0]    time_step,
  input  logic [AREA_W-1:0]  cell_area,
  input  logic [THICK_W-1:0] thickness,
  gwh_result_if.source       results
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_MAC   = 3'd1;
  localparam logic [2:0] B_NORM  = 3'd2;
  localparam logic [2:0] B_SCALE = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_FIN   = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  localparam int ACC_W  = 80;
  localparam int MAG_W  = 79;
  localparam int SACC_W = 95;
  localparam int NUM_W  = 71;
  localparam int DSH_W  = 65;
  localparam int QUO_W  = 34;

  localparam logic [5:0] DIV_TOP = 6'd33;
  localparam logic [HEAD_W-1:0] HEAD_MAX = 32'h7FFF_FFFF;
  localparam logic [HEAD_W-1:0] HEAD_MIN = 32'h8000_0000;

  logic [2:0]              state;
  logic [3:0]              op;
  job_t                    job;
  logic [3:0][41:0]        kt;
  logic [3:0][32:0]        dif;
  logic [31:0]             dval;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        prod;
  logic                    prod_v;
  logic                    qneg;
  logic [MAG_W-1:0]        qmag;
  logic [SACC_W-1:0]       sacc;
  logic [SACC_W-1:0]       sprod;
  logic                    sprod_v;
  logic [NUM_W-1:0]        nrem;
  logic [DSH_W-1:0]        dsh;
  logic [QUO_W-1:0]        quo;
  logic [5:0]              cnt;
  logic                    sat;
  logic [HEAD_W-1:0]       res;

  logic                    out_valid;
  logic [CNT_W-1:0]        out_row;
  logic [CNT_W-1:0]        out_col;
  logic [HEAD_W-1:0]       out_head;
  logic                    out_last;

  logic [3:0]              ti;
  logic [1:0]              tsel;
  logic                    half;
  logic [32:0]             mag_d;
  logic [20:0]             kpart;
  logic [53:0]             mprod;
  logic [ACC_W-1:0]        mval;
  logic [ACC_W-1:0]        term;
  logic [ACC_W-1:0]        srcterm;
  logic [1:0]              isel;
  logic [AREA_W-1:0]       a_eff;
  logic [YIELD_W-1:0]      y_eff;
  logic [26:0]             chunk;
  logic [42:0]             cprod;
  logic [SACC_W-1:0]       cval;
  logic                    ge;
  logic [NUM_W-1:0]        dsh_x;
  logic [34:0]             sum;
  logic [34:0]             dq;
  logic                    load_out;

  assign pop = (state == B_IDLE) && !empty;

  // Flux term of one neighbor, half of the conductance at a time
  always_comb begin
    ti      = op - 4'd4;
    tsel    = ti[2:1];
    half    = ti[0];
    isel    = op[1:0];
    mag_d   = dif[tsel][32] ? (33'd0 - dif[tsel]) : dif[tsel];
    kpart   = half ? kt[tsel][41:21] : kt[tsel][20:0];
    mprod   = 54'(mag_d) * 54'(kpart);
    mval    = half ? (ACC_W'(mprod) << 21) : ACC_W'(mprod);
    if (!job.nv[tsel]) begin
      term = '0;
    end else if (dif[tsel][32]) begin
      term = ACC_W'(0) - mval;
    end else begin
      term = mval;
    end
    srcterm = ACC_W'(0) - ({{(ACC_W - SRC_W){job.src[SRC_W-1]}}, job.src} << 24);
    a_eff   = (cell_area == '0) ? AREA_W'(1) : cell_area;
    y_eff   = (job.sy == '0) ? YIELD_W'(1) : job.sy;
  end

  // Time step scaling, one slice of the flux magnitude at a time
  always_comb begin
    case (op[1:0])
      2'd0:    chunk = qmag[26:0];
      2'd1:    chunk = qmag[53:27];
      2'd2:    chunk = {2'b00, qmag[78:54]};
      default: chunk = '0;
    endcase
    cprod = 43'(chunk) * 43'(time_step);
    case (op[1:0])
      2'd0:    cval = SACC_W'(cprod);
      2'd1:    cval = SACC_W'(cprod) << 27;
      2'd2:    cval = SACC_W'(cprod) << 54;
      default: cval = '0;
    endcase
  end

  // Division step and final sum
  always_comb begin
    dsh_x = NUM_W'(dsh);
    ge    = nrem >= dsh_x;
    dq    = {2'b00, quo[32:0]};
    sum   = {{3{job.hc[HEAD_W-1]}}, job.hc} + (qneg ? (35'd0 - dq) : dq);
  end

  assign load_out = (state == B_OUT) && (!out_valid || results.ready);

  // Job sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      op      <= 4'd0;
      prod_v  <= 1'b0;
      sprod_v <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!empty) begin
            op     <= 4'd0;
            prod_v <= 1'b0;
            state  <= job_in.calc ? B_MAC : B_OUT;
          end
        end
        B_MAC: begin
          op <= op + 4'd1;
          if (op >= 4'd4 && op <= 4'd12) begin
            prod_v <= 1'b1;
          end else begin
            prod_v <= 1'b0;
          end
          if (op == 4'd13) begin
            state <= B_NORM;
          end
        end
        B_NORM: begin
          op      <= 4'd0;
          sprod_v <= 1'b0;
          state   <= B_SCALE;
        end
        B_SCALE: begin
          op      <= op + 4'd1;
          sprod_v <= (op <= 4'd2);
          if (op == 4'd4) begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (cnt == 6'd0) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          state <= B_OUT;
        end
        B_OUT: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) begin
          job <= job_in;
          acc <= '0;
          res <= job_in.hc;
        end
      end
      B_MAC: begin
        if (op <= 4'd3) begin
          kt[isel]  <= 42'(job.nk[isel]) * 42'(thickness);
          dif[isel] <= {job.nh[isel][HEAD_W-1], job.nh[isel]}
                       - {job.hc[HEAD_W-1], job.hc};
        end
        if (op == 4'd0) begin
          dval <= 32'(a_eff) * 32'(y_eff);
        end
        if (op == 4'd12) begin
          prod <= srcterm;
        end else begin
          prod <= term;
        end
        if (prod_v) begin
          acc <= acc + prod;
        end
      end
      B_NORM: begin
        qneg <= acc[ACC_W-1];
        qmag <= acc[ACC_W-1] ? MAG_W'(ACC_W'(0) - acc) : acc[MAG_W-1:0];
        sacc <= '0;
      end
      B_SCALE: begin
        sprod <= cval;
        if (sprod_v) begin
          sacc <= sacc + sprod;
        end
        if (op == 4'd4) begin
          nrem <= sacc[SACC_W-1:24];
          dsh  <= {dval, 33'd0};
          quo  <= '0;
          sat  <= 1'b0;
          cnt  <= DIV_TOP;
        end
      end
      B_DIV: begin
        if (ge) begin
          nrem <= nrem - dsh_x;
        end
        if (ge && (cnt == DIV_TOP)) begin
          sat <= 1'b1;
        end
        quo <= {quo[QUO_W-2:0], ge};
        dsh <= dsh >> 1;
        cnt <= cnt - 6'd1;
      end
      B_FIN: begin
        if (sat) begin
          res <= qneg ? HEAD_MIN : HEAD_MAX;
        end else if (!sum[34] && (sum[33:31] != 3'b000)) begin
          res <= HEAD_MAX;
        end else if (sum[34] && (sum[33:31] != 3'b111)) begin
          res <= HEAD_MIN;
        end else begin
          res <= sum[HEAD_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row  <= job.row;
      out_col  <= job.col;
      out_head <= res;
      out_last <= job.last;
    end
  end

  assign results.valid        = out_valid;
  assign results.row_index    = out_row;
  assign results.column_index = out_col;
  assign results.new_head     = out_head;
  assign results.last_of_run  = out_last;

endmodule

`default_nettype wire

/* hw/rtl/groundwater_head_stencil_update.sv */
// Order: a cell is reported one grid row after it enters, a last-row cell also as it enters;
// the arithmetic unit takes an updated cell through dequeue, flux sum, normalize, scaling,
// division, saturation and output, and a passed-through cell through dequeue and output.
// Flow: the front end takes no new cell until its accept, 4 reads, write and 2 pushes end;
// the pushes wait on a full queue; interior rows are limited by the shared arithmetic unit.
// Reset: synchronous; clears counters, queue and result register; line stores are not cleared.
// ----------------------------------------------------------------------------
// groundwater_head_stencil_update
// Explicit finite-difference head update over a raster-ordered cell stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module groundwater_head_stencil_update import gwh_pkg::*; #(
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gwh_cell_if.sink      cells,
  gwh_result_if.source  results,
  gwh_cfg_if.sink       cfg
);

  logic [TS_W-1:0]    time_step;
  logic [AREA_W-1:0]  cell_area;
  logic [THICK_W-1:0] thickness;
  logic [ROWS_W-1:0]  grid_rows;

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t pop_job;
  logic empty;

  assign cfg.ready = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      cell_area <= CELL_AREA_RST;
      thickness <= THICKNESS_RST;
      grid_rows <= GRID_ROWS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_TIME_STEP: time_step <= cfg.data;
        CFG_CELL_AREA: cell_area <= cfg.data;
        CFG_THICKNESS: thickness <= cfg.data[THICK_W-1:0];
        CFG_GRID_ROWS: grid_rows <= cfg.data[ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gwh_front #(.GRID_COLS(GRID_COLS)) u_front (
    .clk(clk), .rst(rst), .cells(cells), .grid_rows(grid_rows),
    .push(push), .push_job(push_job), .full(full)
  );

  gwh_job_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .full(full),
    .pop(pop), .pop_job(pop_job), .empty(empty)
  );

  gwh_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .pop(pop), .job_in(pop_job),
    .time_step(time_step), .cell_area(cell_area), .thickness(thickness),
    .results(results)
  );

endmodule

`default_nettype wire

/* tb/groundwater_head_stencil_update_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// groundwater_head_stencil_update_tb
// Streams raster-ordered grid sweeps into the head update block under random
// source and sink idling. A local predictor keeps its own line stores,
// counters and register copies, works out each emitted cell in wide signed
// arithmetic and checks every result transfer against the oldest expected
// cell. The phases cover reset defaults, clamped row counts, a sweep cut
// short by a lowered row count, zero divisors and the register extremes.
// ----------------------------------------------------------------------------

module groundwater_head_stencil_update_tb;
  import gwh_pkg::*;

  localparam int COLS       = GRID_COLS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 80;

  localparam logic signed [127:0] HEAD_MAX = 128'sd2147483647;
  localparam logic signed [127:0] HEAD_MIN = -HEAD_MAX - 1;

  typedef struct {
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
    logic [HEAD_W-1:0] head;
    logic              last;
  } cell_out_t;

  logic clk;
  logic rst;

  gwh_cell_if   cells_if();
  gwh_result_if results_if();
  gwh_cfg_if    cfg_if();

  groundwater_head_stencil_update #(.GRID_COLS(COLS)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Predictor state
  logic [HEAD_W-1:0]  head_rows [2][COLS];
  logic [COND_W-1:0]  cond_rows [2][COLS];
  logic [YIELD_W-1:0] yield_row [COLS];
  logic [SRC_W-1:0]   src_row [COLS];
  int unsigned        row_cnt;
  int unsigned        col_cnt;
  logic [TS_W-1:0]    time_step;
  logic [AREA_W-1:0]  cell_area;
  logic [THICK_W-1:0] thickness;
  logic [ROWS_W-1:0]  grid_rows;

  cell_out_t expected_cells[$];
  int        failures;
  int        idle_cycles;
  logic      quiet;
  logic signed [HEAD_W-1:0] head_base;

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Random idle length: mostly none or short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Explicit update of one interior cell
  function automatic logic [HEAD_W-1:0] updated_head(
    logic signed [31:0] hc, logic [3:0][31:0] nh, logic [3:0][31:0] nk,
    logic [3:0] nv, logic [15:0] sy, logic signed [31:0] src);
    logic signed [127:0] flow, hcw, hnw, kw, thw, srcw, tsw, den, quo, sum;
    logic [15:0] area, yl;
    flow = 0;
    hcw  = hc;
    thw  = {118'd0, thickness};
    for (int i = 0; i < 4; i++) begin
      if (nv[i]) begin
        hnw = $signed(nh[i]);
        kw  = {96'd0, nk[i]};
        flow = flow + (hnw - hcw) * kw * thw;
      end
    end
    srcw = src;
    flow = flow - (srcw <<< 24);
    area = (cell_area == 0) ? 16'd1 : cell_area;
    yl   = (sy == 0) ? 16'd1 : sy;
    tsw  = {112'd0, time_step};
    den  = {112'd0, area};
    den  = (den * {112'd0, yl}) <<< 24;
    quo  = (flow * tsw) / den;
    sum  = hcw + quo;
    if (sum > HEAD_MAX) sum = HEAD_MAX;
    if (sum < HEAD_MIN) sum = HEAD_MIN;
    return sum[31:0];
  endfunction

  function automatic void push_cell(int unsigned r, int unsigned c, logic [31:0] h);
    cell_out_t e;
    e.row  = r[CNT_W-1:0];
    e.col  = c[CNT_W-1:0];
    e.head = h;
    e.last = 1'b0;
    expected_cells.push_back(e);
  endfunction

  // Advance the predictor by one accepted cell
  function automatic void predict_cell(logic [31:0] h, logic [31:0] k, logic [15:0] sy,
                                       logic [31:0] src);
    int unsigned rows, r, c, cur, prv, n;
    logic last_row;
    logic [3:0][31:0] nh, nk;
    logic [3:0] nv;
    rows = (grid_rows < ROWS_MIN) ? ROWS_MIN : (grid_rows > ROWS_MAX) ? ROWS_MAX : grid_rows;
    r = row_cnt;
    c = (col_cnt >= COLS) ? 0 : col_cnt;
    cur = r & 1;
    prv = cur ^ 1;
    last_row = (r >= rows - 1);
    n = 0;
    if (r == 1) begin
      push_cell(0, c, head_rows[prv][c]);
      n++;
    end else if (r > 1) begin
      nh = '0;
      nk = '0;
      nh[0] = head_rows[cur][c];
      nk[0] = cond_rows[cur][c];
      nh[1] = h;
      nk[1] = k;
      nv[0] = 1'b1;
      nv[1] = 1'b1;
      nv[2] = (c >= 1);
      nv[3] = (c + 1 < COLS);
      if (nv[2]) begin
        nh[2] = head_rows[prv][c-1];
        nk[2] = cond_rows[prv][c-1];
      end
      if (nv[3]) begin
        nh[3] = head_rows[prv][c+1];
        nk[3] = cond_rows[prv][c+1];
      end
      push_cell(r - 1, c, updated_head(head_rows[prv][c], nh, nk, nv, yield_row[c],
                                       src_row[c]));
      n++;
    end
    head_rows[cur][c] = h;
    cond_rows[cur][c] = k;
    yield_row[c] = sy;
    src_row[c] = src;
    if (last_row) begin
      push_cell(r, c, h);
      n++;
    end
    if (n > 0) expected_cells[$].last = 1'b1;
    c++;
    if (c >= COLS) begin
      c = 0;
      r = last_row ? 0 : r + 1;
    end
    row_cnt = r & 12'hFFF;
    col_cnt = c & 12'hFFF;
  endfunction

  // Send one cell and hold until the transfer
  task automatic send_cell(logic [31:0] h, logic [31:0] k, logic [15:0] sy, logic [31:0] src);
    int gap;
    cells_if.valid          <= 1'b1;
    cells_if.cell_head      <= h;
    cells_if.conductivity   <= k;
    cells_if.specific_yield <= sy;
    cells_if.source_rate    <= src;
    @(posedge clk);
    while (!cells_if.ready) @(posedge clk);
    predict_cell(h, k, sy, src);
    gap = gap_len();
    if (gap > 0) begin
      cells_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_cell();
    logic [31:0] h, k, src;
    logic [15:0] sy;
    case ($urandom_range(0, 9))
      0: h = $urandom;
      1: h = ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: h = head_base + $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
    endcase
    k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h100000);
    case ($urandom_range(0, 19))
      0: sy = 16'd0;
      1: sy = 16'hFFFF;
      2: sy = 16'd1;
      default: sy = 16'($urandom_range(1, 65535));
    endcase
    src = ($urandom_range(0, 3) == 0) ? $urandom
                                      : $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
    send_cell(h, k, sy, src);
  endtask

  task automatic send_rows(int nrows);
    for (int i = 0; i < nrows * COLS; i++) send_random_cell();
  endtask

  // Hold the source until every expected cell has arrived, then let the back end settle
  task automatic drain();
    cells_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_TIME_STEP: time_step = value;
      CFG_CELL_AREA: cell_area = value;
      CFG_THICKNESS: thickness = value[THICK_W-1:0];
      CFG_GRID_ROWS: grid_rows = value[ROWS_W-1:0];
      default: ;
    endcase
  endtask

  // Field extremes at the head of a sweep under reset defaults
  task automatic test_defaults();
    logic [31:0] heads [6];
    logic [31:0] conds [3];
    logic [15:0] ylds [3];
    logic [31:0] srcs [3];
    heads = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h1, 32'h00010000};
    conds = '{32'hFFFFFFFF, 32'h0, 32'h00001000};
    ylds  = '{16'd0, 16'd1, 16'hFFFF};
    srcs  = '{32'h7FFFFFFF, 32'h80000000, 32'h0};
    head_base = 32'sh00100000;
    for (int i = 0; i < 24; i++)
      send_cell(heads[i % 6], conds[(i / 2) % 3], ylds[i % 3], srcs[(i / 3) % 3]);
    for (int i = 24; i < 4 * COLS; i++) send_random_cell();
    drain();
  endtask

  // Row count below range, lowered mid-sweep; strongest flow settings
  task automatic test_row_cut();
    write_reg(CFG_GRID_ROWS, 16'd0);
    write_reg(CFG_TIME_STEP, 16'hFFFF);
    write_reg(CFG_CELL_AREA, 16'd1);
    write_reg(CFG_THICKNESS, 16'd1023);
    head_base = $urandom;
    quiet = 1'b1;
    send_rows(1);
    quiet = 1'b0;
    send_rows(3);
    drain();
  endtask

  // Zero time step, zero thickness, zero area, row count above range
  task automatic test_zero_terms();
    write_reg(CFG_TIME_STEP, 16'd0);
    write_reg(CFG_THICKNESS, 16'd0);
    write_reg(CFG_CELL_AREA, 16'd0);
    write_reg(CFG_GRID_ROWS, 16'h1FFF);
    send_rows(2);
    drain();
  endtask

  // Weakest flow settings, short sweep ending at the counter
  task automatic test_minimum_scale();
    write_reg(CFG_TIME_STEP, 16'd1);
    write_reg(CFG_CELL_AREA, 16'hFFFF);
    write_reg(CFG_THICKNESS, 16'd1);
    write_reg(CFG_GRID_ROWS, 16'd4);
    head_base = -32'sh00400000;
    send_rows(2);
    drain();
  endtask

  // Mid-range settings with a full stop of the source in the middle of a row
  task automatic test_mixed();
    write_reg(CFG_TIME_STEP, 16'($urandom_range(100, 20000)));
    write_reg(CFG_CELL_AREA, 16'($urandom_range(10, 5000)));
    write_reg(CFG_THICKNESS, 16'($urandom_range(5, 500)));
    write_reg(CFG_GRID_ROWS, 16'd5);
    head_base = $signed($urandom) >>> 4;
    for (int i = 0; i < COLS / 2; i++) send_random_cell();
    drain();
    for (int i = COLS / 2; i < 2 * COLS; i++) send_random_cell();
    drain();
  endtask

  // Result sink: random stalls, with stall-free stretches
  initial begin
    int run;
    results_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run = $urandom_range(1, 40);
      results_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      run = gap_len();
      if (run > 0) begin
        results_if.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expected cell
  always @(posedge clk) begin
    cell_out_t e;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result row %0d col %0d", results_if.row_index,
               results_if.column_index);
        failures++;
      end else begin
        e = expected_cells.pop_front();
        if (results_if.row_index !== e.row) begin
          $error("row_index expected %0d actual %0d", e.row, results_if.row_index);
          failures++;
        end
        if (results_if.column_index !== e.col) begin
          $error("column_index expected %0d actual %0d", e.col, results_if.column_index);
          failures++;
        end
        if (results_if.new_head !== e.head) begin
          $error("new_head expected %h actual %h", e.head, results_if.new_head);
          failures++;
        end
        if (results_if.last_of_run !== e.last) begin
          $error("last_of_run expected %0d actual %0d", e.last, results_if.last_of_run);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cells_if.valid && cells_if.ready) || (results_if.valid && results_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("groundwater_head_stencil_update verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cells_if.valid = 1'b0;
    cells_if.cell_head = '0;
    cells_if.conductivity = '0;
    cells_if.specific_yield = '0;
    cells_if.source_rate = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TIME_STEP;
    cfg_if.data = '0;
    failures = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    head_base = '0;
    row_cnt = 0;
    col_cnt = 0;
    time_step = TIME_STEP_RST;
    cell_area = CELL_AREA_RST;
    thickness = THICKNESS_RST;
    grid_rows = GRID_ROWS_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_row_cut();
    test_zero_terms();
    test_minimum_scale();
    test_mixed();

    drain();
    if (failures == 0) begin
      $display("groundwater_head_stencil_update verification clean");
    end else begin
      $display("groundwater_head_stencil_update verification failed");
    end
    $finish;
  end

endmodule
